FILE: rtl/ecs_pkg.sv
`default_nettype none

package ecs_pkg;

  // floor numbers as carried on the stream
  localparam int unsigned FLOOR_W   = 5;
  // highest floor a FLOOR_W-bit number can name
  localparam int unsigned FLOOR_MAX = (1 << FLOOR_W) - 1;

  typedef logic [FLOOR_W-1:0] floor_t;

  // event kinds
  typedef enum logic [1:0] {
    CMD_CABIN  = 2'd0,
    CMD_FLOOR  = 2'd1,
    CMD_ARRIVE = 2'd2,
    CMD_PASS   = 2'd3
  } cmd_e;

  // travel direction
  typedef enum logic [1:0] {
    DIR_STAY = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

endpackage

`default_nettype wire

FILE: rtl/elevator_call_scheduler.sv
`default_nettype none

// Elevator call scheduler. Each input beat is one event: a cabin call, a floor call, an
// arrival at a floor or the passing of a floor (kind on s_axis_tuser, floor number from 1
// on s_axis_tdata). Every event gives exactly one output beat carrying the announced stop
// (meaningful only when m_axis_tuser is high), the travel direction and the busy flag.
// The block keeps a bitmap of requested floors, the current floor, the main target, the
// heading and a busy flag; the next stop comes from a priority scan of the bitmap from the
// current floor toward the target, though a cabin call between the two is itself the stop.
// Floor numbers of 0 or above NUM_FLOORS leave the state untouched and give a beat with no
// stop. Timing: an event is held in the input register, then one combinational pass feeds
// the state and output registers; one event is taken every cycle unless the output stalls.
// While a result waits to be read, a new event may still enter the input register if empty.
module elevator_call_scheduler #(
  parameter int NUM_FLOORS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] floor_number, [7:5] zero
  input  wire logic [1:0] s_axis_tuser,   // [1:0] cmd
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [4:0] stop_floor, [6:5] travel_dir, [7] busy_flag
  output logic [0:0]      m_axis_tuser    // [0] emit_valid
);

  // floors beyond what a floor number can name never get a request bit
  localparam int MAP_W = (NUM_FLOORS < int'(ecs_pkg::FLOOR_MAX)) ?
                         NUM_FLOORS : int'(ecs_pkg::FLOOR_MAX);

  // lowest requested floor, 0 if none
  function automatic ecs_pkg::floor_t lowest_req(input logic [MAP_W-1:0] v);
    ecs_pkg::floor_t r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) r = ecs_pkg::FLOOR_W'(i + 1);
    end
    return r;
  endfunction

  // highest requested floor, 0 if none
  function automatic ecs_pkg::floor_t highest_req(input logic [MAP_W-1:0] v);
    ecs_pkg::floor_t r;
    r = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (v[i]) r = ecs_pkg::FLOOR_W'(i + 1);
    end
    return r;
  endfunction

  // nearest request from pos toward tgt, pos included; 0 if none
  function automatic ecs_pkg::floor_t scan_stop(input logic [MAP_W-1:0] map,
                                                input ecs_pkg::floor_t pos,
                                                input ecs_pkg::floor_t tgt);
    logic [MAP_W-1:0] m;
    for (int i = 0; i < MAP_W; i++) begin
      if (tgt > pos) m[i] = map[i] && ((i + 1) >= int'(pos));
      else           m[i] = map[i] && ((i + 1) <= int'(pos));
    end
    return (tgt > pos) ? lowest_req(m) : highest_req(m);
  endfunction

  // handshake
  logic in_valid_q;
  logic out_ready;
  logic advance;
  logic s_accept;

  // input register
  ecs_pkg::cmd_e   in_cmd_q;
  ecs_pkg::floor_t in_floor_q;

  // scheduler state
  logic [MAP_W-1:0] map_q, map_d;
  ecs_pkg::floor_t  pos_q, pos_d;
  ecs_pkg::floor_t  tgt_q, tgt_d;
  ecs_pkg::dir_e    hd_q, hd_d;
  logic             busy_q, busy_d;

  // output register
  logic            out_valid_q;
  logic            emit_q, emit_d;
  ecs_pkg::floor_t stop_q, stop_d;

  // per-event working values
  logic             in_range;
  logic [MAP_W-1:0] fl_bit;
  ecs_pkg::floor_t  tgt_call;
  ecs_pkg::floor_t  tgt_ext;
  logic             call_between;
  logic             call_beyond;
  ecs_pkg::floor_t  scan_call;
  logic [MAP_W-1:0] map_arr;
  ecs_pkg::floor_t  tgt_arr;
  ecs_pkg::floor_t  scan_arr;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_cmd_q   <= ecs_pkg::cmd_e'(s_axis_tuser);
      in_floor_q <= s_axis_tdata[ecs_pkg::FLOOR_W-1:0];
    end
  end

  always_comb begin
    in_range = (in_floor_q != '0) && (int'(in_floor_q) <= NUM_FLOORS);
    fl_bit   = MAP_W'(1) << (in_floor_q - ecs_pkg::FLOOR_W'(1));

    // calls: adopt the floor as target when there is none
    tgt_call     = (tgt_q == '0) ? in_floor_q : tgt_q;
    call_between = ((hd_q == ecs_pkg::DIR_UP) && (in_floor_q < tgt_call) &&
                    (in_floor_q > pos_q)) ||
                   ((hd_q == ecs_pkg::DIR_DOWN) && (in_floor_q > tgt_call) &&
                    (in_floor_q < pos_q));
    // floor calls stretch the target past its end
    call_beyond  = ((hd_q == ecs_pkg::DIR_UP) && (in_floor_q > tgt_call)) ||
                   ((hd_q == ecs_pkg::DIR_DOWN) && (in_floor_q < tgt_call));
    tgt_ext      = ((in_cmd_q == ecs_pkg::CMD_FLOOR) && call_beyond) ? in_floor_q : tgt_call;
    scan_call    = scan_stop(map_q | fl_bit, pos_q, tgt_ext);

    // arrival: clear the floor, repick the target when it is reached
    map_arr  = map_q & ~fl_bit;
    if (in_floor_q == tgt_q) begin
      tgt_arr = (hd_q == ecs_pkg::DIR_UP) ? highest_req(map_arr) : lowest_req(map_arr);
    end else begin
      tgt_arr = tgt_q;
    end
    scan_arr = scan_stop(map_arr, in_floor_q, tgt_arr);
  end

  always_comb begin
    map_d  = map_q;
    pos_d  = pos_q;
    tgt_d  = tgt_q;
    hd_d   = hd_q;
    busy_d = busy_q;
    emit_d = 1'b0;
    stop_d = '0;
    if (advance && in_range) begin
      case (in_cmd_q)
        ecs_pkg::CMD_CABIN, ecs_pkg::CMD_FLOOR: begin
          busy_d = 1'b1;
          map_d  = map_q | fl_bit;
          emit_d = 1'b1;
          if ((in_cmd_q == ecs_pkg::CMD_CABIN) && call_between) begin
            tgt_d  = tgt_call;
            stop_d = in_floor_q;
          end else begin
            tgt_d  = tgt_ext;
            stop_d = (scan_call != '0) ? scan_call : in_floor_q;
            hd_d   = (pos_q > tgt_ext) ? ecs_pkg::DIR_DOWN : ecs_pkg::DIR_UP;
          end
        end
        ecs_pkg::CMD_ARRIVE: begin
          // arrivals while free are ignored
          if (busy_q) begin
            pos_d = in_floor_q;
            map_d = map_arr;
            tgt_d = tgt_arr;
            if (scan_arr != '0) begin
              hd_d   = (in_floor_q > tgt_arr) ? ecs_pkg::DIR_DOWN : ecs_pkg::DIR_UP;
              stop_d = scan_arr;
              emit_d = 1'b1;
            end else begin
              busy_d = 1'b0;
            end
          end
        end
        ecs_pkg::CMD_PASS: begin
          pos_d = in_floor_q;
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      pos_q  <= ecs_pkg::FLOOR_W'(1);
      tgt_q  <= '0;
      hd_q   <= ecs_pkg::DIR_STAY;
      busy_q <= 1'b0;
    end else begin
      map_q  <= map_d;
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      hd_q   <= hd_d;
      busy_q <= busy_d;
    end
  end

  // output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // direction and busy are read straight from the state, which only moves on advance
  always_ff @(posedge clk_i) begin
    if (advance) begin
      emit_q <= emit_d;
      stop_q <= stop_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {busy_q, hd_q, stop_q};
  assign m_axis_tuser  = emit_q;

endmodule

`default_nettype wire
